// File: sv/wsst_pkg.sv
`default_nettype none

package wsst_pkg;

   // Default sizes of the tree and of its arithmetic.
   localparam int DEF_LEVELS      = 10;
   localparam int DEF_WEIGHT_BITS = 32;
   localparam int DEF_RAND_BITS   = 16;

   // Port field widths, fixed by the interface.
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 10;
   localparam int WEIGHT_W = 32;
   localparam int RAND_W   = 16;
   localparam int TOTAL_W  = 42;

   // Sums never grow past 64 bits.
   localparam int MAX_SUM_BITS = 64;

   // Action codes carried by each input item.
   localparam logic [ACTION_W-1:0] ACT_SET    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_GET    = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

   // One result item as it leaves the sequencer.
   typedef struct packed {
      logic [INDEX_W-1:0]  chosen_index;
      logic [WEIGHT_W-1:0] leaf_weight;
      logic [TOTAL_W-1:0]  total_weight;
   } result_type;

endpackage

`default_nettype wire

// File: sv/wsst_node_ram.sv
`default_nettype none

module wsst_node_ram #(
   parameter int ADDR_BITS = 11,
   parameter int DATA_BITS = 42
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

`default_nettype wire

// File: sv/wsst_scale.sv
`default_nettype none

module wsst_scale #(
   parameter int SUM_BITS  = 42,
   parameter int RAND_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [SUM_BITS-1:0]  total,
   input  wire logic [RAND_BITS-1:0] rand_frac,
   output logic                      done,
   output logic      [SUM_BITS-1:0]  scaled
);

   // The total is split into chunks; one chunk times the fraction per cycle.
   localparam int CHUNK  = 16;
   localparam int NCHUNK = (SUM_BITS + CHUNK - 1) / CHUNK;
   localparam int TOT_W  = NCHUNK * CHUNK;
   localparam int PROD_W = CHUNK + RAND_BITS;
   localparam int ACC_W  = TOT_W + RAND_BITS;
   localparam int CNT_W  = $clog2(NCHUNK + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [TOT_W-1:0]     tot_ff, tot_in;
   logic [RAND_BITS-1:0] r_ff, r_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [PROD_W-1:0]    chunk_ext;
   logic [PROD_W-1:0]    rand_ext;

   assign chunk_ext = {{RAND_BITS{1'b0}}, tot_ff[TOT_W-1 -: CHUNK]};
   assign rand_ext  = {{CHUNK{1'b0}}, r_ff};

   // Most significant chunk first: the accumulator shifts up one chunk per step.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      tot_in  = tot_ff;
      r_in    = r_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NCHUNK);
         tot_in  = TOT_W'(total);
         r_in    = rand_frac;
         prod_in = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (acc_ff << CHUNK) + ACC_W'(prod_ff);
         if (cnt_ff != '0) begin
            prod_in = chunk_ext * rand_ext;
            tot_in  = tot_ff << CHUNK;
            cnt_in  = cnt_ff - CNT_W'(1);
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      tot_ff  <= tot_in;
      r_ff    <= r_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // The product shifted down by the fraction width is below the total when the total is nonzero.
   assign done   = done_ff;
   assign scaled = acc_ff[RAND_BITS +: SUM_BITS];

endmodule

`default_nettype wire

// File: sv/wsst_ctrl.sv
`default_nettype none

module wsst_ctrl #(
   parameter int LEVELS      = 10,
   parameter int WEIGHT_BITS = 32,
   parameter int RAND_BITS   = 16,
   parameter int SUM_BITS    = 42
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [wsst_pkg::ACTION_W-1:0]        req_action,
   input  wire logic [wsst_pkg::INDEX_W-1:0]         req_leaf_index,
   input  wire logic [wsst_pkg::WEIGHT_W-1:0]        req_weight,
   input  wire logic [wsst_pkg::RAND_W-1:0]          req_random_fraction,
   output logic                                      res_valid,
   input  wire logic                                 res_ready,
   output wsst_pkg::result_type                      res,
   output logic                                      ram_we,
   output logic      [LEVELS:0]                      ram_waddr,
   output logic      [SUM_BITS-1:0]                  ram_wdata,
   output logic                                      ram_re,
   output logic      [LEVELS:0]                      ram_raddr,
   input  wire logic [SUM_BITS-1:0]                  ram_rdata,
   output logic                                      scale_start,
   output logic      [SUM_BITS-1:0]                  scale_total,
   output logic      [RAND_BITS-1:0]                 scale_rand,
   input  wire logic                                 scale_done,
   input  wire logic [SUM_BITS-1:0]                  scale_d
);

   localparam int ADDR_BITS = LEVELS + 1;
   localparam int I_IN = (LEVELS < wsst_pkg::INDEX_W) ? LEVELS : wsst_pkg::INDEX_W;
   localparam int W_IN = (WEIGHT_BITS < wsst_pkg::WEIGHT_W) ? WEIGHT_BITS : wsst_pkg::WEIGHT_W;
   localparam int R_IN = (RAND_BITS < wsst_pkg::RAND_W) ? RAND_BITS : wsst_pkg::RAND_W;

   // Sequencer states.
   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CLEAR = 3'd2;
   localparam logic [2:0] S_SET   = 3'd3;
   localparam logic [2:0] S_SCALE = 3'd4;
   localparam logic [2:0] S_WALK  = 3'd5;
   localparam logic [2:0] S_GET   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]                     state_ff, state_in;
   logic [ADDR_BITS-1:0]           node_ff, node_in;
   logic [SUM_BITS-1:0]            val_ff, val_in;
   logic [SUM_BITS-1:0]            total_ff, total_in;
   logic [wsst_pkg::INDEX_W-1:0]   chosen_ff, chosen_in;
   logic [wsst_pkg::WEIGHT_W-1:0]  lw_ff, lw_in;

   logic [ADDR_BITS-1:0]           leaf_node;
   logic [SUM_BITS-1:0]            weight_ext;
   logic [ADDR_BITS-1:0]           parent;
   logic [SUM_BITS-1:0]            sum_v;
   logic [SUM_BITS-1:0]            val_sub;
   logic                           go_right;
   logic [ADDR_BITS-1:0]           walk_next;

   // Input fields reduced to the tree's sizes.
   assign leaf_node  = {1'b1, LEVELS'(req_leaf_index[I_IN-1:0])};
   assign weight_ext = SUM_BITS'(req_weight[W_IN-1:0]);
   assign scale_rand = RAND_BITS'(req_random_fraction[R_IN-1:0]);
   assign scale_total = total_ff;

   // Upward pass adds the sibling; downward walk compares with the left child.
   assign parent    = {1'b0, node_ff[ADDR_BITS-1:1]};
   assign sum_v     = val_ff + ram_rdata;
   assign val_sub   = val_ff - ram_rdata;
   assign go_right  = val_ff > ram_rdata;
   assign walk_next = {node_ff[ADDR_BITS-2:0], go_right};

   always_comb begin
      state_in    = state_ff;
      node_in     = node_ff;
      val_in      = val_ff;
      total_in    = total_ff;
      chosen_in   = chosen_ff;
      lw_in       = lw_ff;
      ram_we      = 1'b0;
      ram_waddr   = node_ff;
      ram_wdata   = '0;
      ram_re      = 1'b0;
      ram_raddr   = node_ff;
      scale_start = 1'b0;
      case (state_ff)
         // Sweep every entry to zero, after reset or on a clear item.
         S_INIT, S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = node_ff;
            ram_wdata = '0;
            node_in   = node_ff + ADDR_BITS'(1);
            if (node_ff == '1) begin
               total_in = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         // Take a new item: issue its first memory access, or start the multiplier or the sweep.
         S_IDLE: begin
            if (req_valid) begin
               chosen_in = req_leaf_index;
               lw_in     = '0;
               case (req_action)
                  wsst_pkg::ACT_SET: begin
                     ram_we    = 1'b1;
                     ram_waddr = leaf_node;
                     ram_wdata = weight_ext;
                     ram_re    = 1'b1;
                     ram_raddr = leaf_node ^ ADDR_BITS'(1);
                     node_in   = leaf_node;
                     val_in    = weight_ext;
                     state_in  = S_SET;
                  end
                  wsst_pkg::ACT_SELECT: begin
                     scale_start = 1'b1;
                     state_in    = S_SCALE;
                  end
                  wsst_pkg::ACT_GET: begin
                     ram_re    = 1'b1;
                     ram_raddr = leaf_node;
                     state_in  = S_GET;
                  end
                  wsst_pkg::ACT_CLEAR: begin
                     node_in  = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         // One level per cycle: write the parent sum, fetch the parent's sibling.
         S_SET: begin
            ram_we    = 1'b1;
            ram_waddr = parent;
            ram_wdata = sum_v;
            val_in    = sum_v;
            node_in   = parent;
            if (parent == ADDR_BITS'(1)) begin
               total_in = sum_v;
               state_in = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = parent ^ ADDR_BITS'(1);
            end
         end
         // Wait for the scaled target, then fetch the root's left child.
         S_SCALE: begin
            if (scale_done) begin
               val_in    = scale_d;
               node_in   = ADDR_BITS'(1);
               ram_re    = 1'b1;
               ram_raddr = ADDR_BITS'(2);
               state_in  = S_WALK;
            end
         end
         // One level per cycle down the tree; ties go left.
         S_WALK: begin
            node_in = walk_next;
            if (go_right) begin
               val_in = val_sub;
            end
            if (walk_next[ADDR_BITS-1]) begin
               chosen_in = wsst_pkg::INDEX_W'(walk_next[LEVELS-1:0]);
               state_in  = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = {walk_next[ADDR_BITS-2:0], 1'b0};
            end
         end
         S_GET: begin
            lw_in    = wsst_pkg::WEIGHT_W'(ram_rdata);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state; reset starts the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         node_ff  <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         node_ff  <= node_in;
         total_ff <= total_in;
      end
   end

   // Working value and result fields.
   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      chosen_ff <= chosen_in;
      lw_ff     <= lw_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign res_valid        = (state_ff == S_DONE);
   assign res.chosen_index = chosen_ff;
   assign res.leaf_weight  = lw_ff;
   assign res.total_weight = wsst_pkg::TOTAL_W'(total_ff);

   // The multiplier only finishes for a select in progress.
   a_scale_done_in_scale: assert property (@(posedge clock) disable iff (reset)
      scale_done |-> state_ff == S_SCALE)
      else $error("scale result arrived outside a select");

   // The walk never stands on a leaf; it ends as it reaches one.
   a_walk_above_leaves: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> !node_ff[ADDR_BITS-1])
      else $error("walk stands on a leaf node");

   // The end of a clearing sweep leaves a zero total.
   a_clear_zeroes_total: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CLEAR || state_ff == S_INIT) && node_ff == '1) |=> total_ff == '0)
      else $error("total not zero after clear");

   // A finished result holds until the output stage takes it.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_ready) |=> (res_valid && $stable(res)))
      else $error("result dropped or changed before it was taken");

   // The upward pass never reads the entry it writes in the same cycle.
   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> ram_waddr != ram_raddr)
      else $error("read and write of the same entry in one cycle");

endmodule

`default_nettype wire

// File: sv/weighted_sample_sum_tree_unit.sv
// Weighted sampling sum tree over 2^LEVELS leaf weights, with the total at the root.
// Input items (req_valid / req_ready) carry an action: set a leaf weight, select a
// leaf by a random fraction of the total, get a leaf weight, or clear all weights.
// Each item yields exactly one result item (rsp_valid / rsp_ready) that reports the
// chosen or echoed leaf index, the leaf weight for a get, and the total afterwards.
// One item is worked on at a time; the node sums sit in one memory with a registered
// read, and set and select visit one tree level per memory access.
// A select scales the total in a chunked multiplier, then walks the tree; a clear
// sweeps every memory entry. After reset the block sweeps all 2^(LEVELS+1) memory
// entries (2048 at the defaults) to zero with req_ready low, then takes items.
// A result waits in an output register while the receiver stalls; the block takes the
// next item meanwhile and holds that item's result until the register frees.
`default_nettype none

module weighted_sample_sum_tree_unit #(
   parameter int LEVELS      = wsst_pkg::DEF_LEVELS,
   parameter int WEIGHT_BITS = wsst_pkg::DEF_WEIGHT_BITS,
   parameter int RAND_BITS   = wsst_pkg::DEF_RAND_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [wsst_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [wsst_pkg::INDEX_W-1:0]   req_leaf_index,
   input  wire logic [wsst_pkg::WEIGHT_W-1:0]  req_weight,
   input  wire logic [wsst_pkg::RAND_W-1:0]    req_random_fraction,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [wsst_pkg::INDEX_W-1:0]   rsp_chosen_index,
   output logic      [wsst_pkg::WEIGHT_W-1:0]  rsp_leaf_weight,
   output logic      [wsst_pkg::TOTAL_W-1:0]   rsp_total_weight
);

   localparam int ADDR_BITS = LEVELS + 1;
   localparam int SUM_BITS  = (WEIGHT_BITS + LEVELS > wsst_pkg::MAX_SUM_BITS) ?
                              wsst_pkg::MAX_SUM_BITS : WEIGHT_BITS + LEVELS;

   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [SUM_BITS-1:0]   ram_wdata;
   logic                  ram_re;
   logic [ADDR_BITS-1:0]  ram_raddr;
   logic [SUM_BITS-1:0]   ram_rdata;
   logic                  scale_start;
   logic [SUM_BITS-1:0]   scale_total;
   logic [RAND_BITS-1:0]  scale_rand;
   logic                  scale_done;
   logic [SUM_BITS-1:0]   scale_d;
   logic                  res_valid;
   logic                  res_ready;
   wsst_pkg::result_type  res;

   logic                  rsp_valid_ff, rsp_valid_in;
   wsst_pkg::result_type  rsp_ff, rsp_in;

   wsst_node_ram #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (SUM_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   wsst_scale #(
      .SUM_BITS  (SUM_BITS),
      .RAND_BITS (RAND_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .start     (scale_start),
      .total     (scale_total),
      .rand_frac (scale_rand),
      .done      (scale_done),
      .scaled    (scale_d)
   );

   wsst_ctrl #(
      .LEVELS      (LEVELS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .RAND_BITS   (RAND_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_leaf_index      (req_leaf_index),
      .req_weight          (req_weight),
      .req_random_fraction (req_random_fraction),
      .res_valid           (res_valid),
      .res_ready           (res_ready),
      .res                 (res),
      .ram_we              (ram_we),
      .ram_waddr           (ram_waddr),
      .ram_wdata           (ram_wdata),
      .ram_re              (ram_re),
      .ram_raddr           (ram_raddr),
      .ram_rdata           (ram_rdata),
      .scale_start         (scale_start),
      .scale_total         (scale_total),
      .scale_rand          (scale_rand),
      .scale_done          (scale_done),
      .scale_d             (scale_d)
   );

   // Output register: loads a finished item whenever it is empty or being emptied.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_index = rsp_ff.chosen_index;
   assign rsp_leaf_weight  = rsp_ff.leaf_weight;
   assign rsp_total_weight = rsp_ff.total_weight;

endmodule

`default_nettype wire

// File: bench/weighted_sample_sum_tree_unit_test.sv
`timescale 1ns / 100ps

module weighted_sample_sum_tree_unit_test;

   localparam int LEVELS     = wsst_pkg::DEF_LEVELS;
   localparam int LEAF_COUNT = 1 << LEVELS;
   localparam int NODE_COUNT = 2 << LEVELS;
   localparam int SUM_W      = wsst_pkg::DEF_WEIGHT_BITS + wsst_pkg::DEF_LEVELS;
   localparam int PROD_W     = SUM_W + wsst_pkg::RAND_W;
   localparam int MAX_SHOWN  = 10;

   // One input item as the bench sees it.
   typedef struct {
      logic [wsst_pkg::ACTION_W-1:0] action;
      logic [wsst_pkg::INDEX_W-1:0]  leaf;
      logic [wsst_pkg::WEIGHT_W-1:0] weight;
      logic [wsst_pkg::RAND_W-1:0]   fraction;
   } tree_op_type;

   // One row of the directed table; fixed rows carry their result typed in.
   typedef struct {
      tree_op_type          op;
      bit                   fixed;
      wsst_pkg::result_type want;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [wsst_pkg::ACTION_W-1:0] req_action = '0;
   logic [wsst_pkg::INDEX_W-1:0]  req_leaf_index = '0;
   logic [wsst_pkg::WEIGHT_W-1:0] req_weight = '0;
   logic [wsst_pkg::RAND_W-1:0]   req_random_fraction = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [wsst_pkg::INDEX_W-1:0]  rsp_chosen_index;
   logic [wsst_pkg::WEIGHT_W-1:0] rsp_leaf_weight;
   logic [wsst_pkg::TOTAL_W-1:0]  rsp_total_weight;

   // Bench copy of the node sums; node 1 is the root.
   logic [SUM_W-1:0]     tree_sum [0:NODE_COUNT-1];
   wsst_pkg::result_type tree_results_due [$];
   stim_row_type         directed_rows [$];
   int                   mismatches = 0;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;

   weighted_sample_sum_tree_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_leaf_index      (req_leaf_index),
      .req_weight          (req_weight),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_leaf_weight     (rsp_leaf_weight),
      .rsp_total_weight    (rsp_total_weight)
   );

   always #5 clock = ~clock;

   // Applies one item to the bench tree and returns the result it must give.
   function automatic wsst_pkg::result_type sum_tree_apply(input tree_op_type op);
      wsst_pkg::result_type res;
      logic [PROD_W-1:0]    scaled;
      logic [SUM_W-1:0]     aim;
      int                   node;
      res.chosen_index = op.leaf;
      res.leaf_weight  = '0;
      case (op.action)
         wsst_pkg::ACT_SET: begin
            node = LEAF_COUNT + int'(op.leaf);
            tree_sum[node] = SUM_W'(op.weight);
            for (node = node / 2; node >= 1; node = node / 2)
               tree_sum[node] = tree_sum[2 * node] + tree_sum[2 * node + 1];
         end
         wsst_pkg::ACT_SELECT: begin
            // Aim at floor(r * total / 2^16), then walk down; ties go left.
            scaled = PROD_W'(tree_sum[1]) * PROD_W'(op.fraction);
            aim    = scaled[wsst_pkg::RAND_W +: SUM_W];
            node   = 1;
            while (node < LEAF_COUNT) begin
               node = 2 * node;
               if (aim > tree_sum[node]) begin
                  aim  = aim - tree_sum[node];
                  node = node + 1;
               end
            end
            res.chosen_index = wsst_pkg::INDEX_W'(node - LEAF_COUNT);
         end
         wsst_pkg::ACT_GET: begin
            res.leaf_weight =
               wsst_pkg::WEIGHT_W'(tree_sum[LEAF_COUNT + int'(op.leaf)]);
         end
         default: begin
            for (node = 0; node < NODE_COUNT; node++)
               tree_sum[node] = '0;
         end
      endcase
      res.total_weight = wsst_pkg::TOTAL_W'(tree_sum[1]);
      return res;
   endfunction

   function automatic void add_row(input logic [wsst_pkg::ACTION_W-1:0] action,
                                   input logic [wsst_pkg::INDEX_W-1:0] leaf,
                                   input logic [wsst_pkg::WEIGHT_W-1:0] weight,
                                   input logic [wsst_pkg::RAND_W-1:0] fraction,
                                   input bit fixed,
                                   input logic [wsst_pkg::INDEX_W-1:0] chosen,
                                   input logic [wsst_pkg::WEIGHT_W-1:0] leaf_weight,
                                   input logic [wsst_pkg::TOTAL_W-1:0] total);
      stim_row_type row;
      row.op.action          = action;
      row.op.leaf            = leaf;
      row.op.weight          = weight;
      row.op.fraction        = fraction;
      row.fixed              = fixed;
      row.want.chosen_index  = chosen;
      row.want.leaf_weight   = leaf_weight;
      row.want.total_weight  = total;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [wsst_pkg::WEIGHT_W-1:0] random_weight();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return wsst_pkg::WEIGHT_W'($urandom_range(0, 255));
         3:       return 32'd1 << $urandom_range(0, 31);
         default: return wsst_pkg::WEIGHT_W'($urandom());
      endcase
   endfunction

   // Random item: leaves cluster at both ends so selects land on written weights.
   function automatic tree_op_type random_op();
      tree_op_type op;
      int          pick;
      pick = int'($urandom_range(0, 99));
      if (pick < 45)
         op.action = wsst_pkg::ACT_SET;
      else if (pick < 80)
         op.action = wsst_pkg::ACT_SELECT;
      else if (pick < 98)
         op.action = wsst_pkg::ACT_GET;
      else
         op.action = wsst_pkg::ACT_CLEAR;
      case ($urandom_range(0, 4))
         0, 1:    op.leaf = wsst_pkg::INDEX_W'($urandom_range(0, 7));
         2:       op.leaf = wsst_pkg::INDEX_W'($urandom_range(LEAF_COUNT - 8,
                                                              LEAF_COUNT - 1));
         default: op.leaf = wsst_pkg::INDEX_W'($urandom_range(0, LEAF_COUNT - 1));
      endcase
      op.weight = random_weight();
      case ($urandom_range(0, 5))
         0:       op.fraction = '0;
         1:       op.fraction = '1;
         default: op.fraction = wsst_pkg::RAND_W'($urandom_range(0, 65535));
      endcase
      return op;
   endfunction

   // Presents one item, waits for its acceptance and records its result.
   task automatic issue_op(input tree_op_type op, input bit fixed,
                           input wsst_pkg::result_type want);
      wsst_pkg::result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_action          <= op.action;
      req_leaf_index      <= op.leaf;
      req_weight          <= op.weight;
      req_random_fraction <= op.fraction;
      do
         @(posedge clock);
      while (!req_ready);
      predicted = sum_tree_apply(op);
      tree_results_due.push_back(fixed ? want : predicted);
   endtask

   // Result side: check each accepted item, then stall at random.
   always @(posedge clock) begin
      wsst_pkg::result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tree_results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("%0t: unexpected item: index %0d weight %h total %h",
                           $realtime, rsp_chosen_index, rsp_leaf_weight, rsp_total_weight);
            end else begin
               want = tree_results_due.pop_front();
               if (rsp_chosen_index !== want.chosen_index ||
                   rsp_leaf_weight !== want.leaf_weight ||
                   rsp_total_weight !== want.total_weight) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("%0t: mismatch index %0d/%0d weight %h/%h total %h/%h",
                              $realtime, want.chosen_index, rsp_chosen_index,
                              want.leaf_weight, rsp_leaf_weight,
                              want.total_weight, rsp_total_weight);
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Stimulus: directed table, then random items over three idling phases.
   initial begin
      tree_op_type          op;
      wsst_pkg::result_type none;
      int                   n;
      int                   leaf;
      none = '0;
      for (n = 0; n < NODE_COUNT; n++)
         tree_sum[n] = '0;

      // Empty tree, then both extreme leaves at full weight.
      add_row(wsst_pkg::ACT_GET,    10'd0,   32'd0,        16'd0,    1, 10'd0,   32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_SELECT, 10'h3FF, 32'd0,        16'hFFFF, 1, 10'd0,   32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_SET,    10'h3FF, 32'hFFFFFFFF, 16'd0,    1, 10'h3FF, 32'd0,
              42'h0_FFFF_FFFF);
      add_row(wsst_pkg::ACT_SET,    10'd0,   32'hFFFFFFFF, 16'd0,    1, 10'd0,   32'd0,
              42'h1_FFFF_FFFE);
      add_row(wsst_pkg::ACT_SELECT, 10'h155, 32'd0,        16'd0,    1, 10'd0,   32'd0,
              42'h1_FFFF_FFFE);
      add_row(wsst_pkg::ACT_SELECT, 10'h2AA, 32'd0,        16'hFFFF, 1, 10'h3FF, 32'd0,
              42'h1_FFFF_FFFE);
      add_row(wsst_pkg::ACT_GET,    10'h3FF, 32'd0,        16'd0,    1, 10'h3FF,
              32'hFFFFFFFF, 42'h1_FFFF_FFFE);
      // A zero-weight leaf is still chosen when the aim is zero.
      add_row(wsst_pkg::ACT_SET,    10'd0,   32'd0,        16'd0,    1, 10'd0,   32'd0,
              42'h0_FFFF_FFFF);
      add_row(wsst_pkg::ACT_SELECT, 10'h3FF, 32'd0,        16'd0,    1, 10'd0,   32'd0,
              42'h0_FFFF_FFFF);
      add_row(wsst_pkg::ACT_SELECT, 10'd0,   32'd0,        16'd1,    0, 10'd0,   32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_SET,    10'h2AA, 32'hAAAAAAAA, 16'h5555, 0, 10'd0,   32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_SET,    10'h155, 32'h55555555, 16'hAAAA, 0, 10'd0,   32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_GET,    10'h2AA, 32'd0,        16'd0,    0, 10'd0,   32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_SELECT, 10'd0,   32'd0,        16'h8000, 0, 10'd0,   32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_SELECT, 10'd0,   32'd0,        16'h5555, 0, 10'd0,   32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_SELECT, 10'd0,   32'd0,        16'hAAAA, 0, 10'd0,   32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_SET,    10'h200, 32'd1,        16'd0,    0, 10'd0,   32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_SELECT, 10'd0,   32'd0,        16'h7FFF, 0, 10'd0,   32'd0,
              42'd0);
      // Clear echoes the index and empties the tree.
      add_row(wsst_pkg::ACT_CLEAR,  10'h155, 32'hFFFFFFFF, 16'hFFFF, 1, 10'h155, 32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_GET,    10'h3FF, 32'd0,        16'd0,    1, 10'h3FF, 32'd0,
              42'd0);
      add_row(wsst_pkg::ACT_SELECT, 10'h3FF, 32'd0,        16'hFFFF, 1, 10'd0,   32'd0,
              42'd0);
      // Total of one: the aim rounds down to zero and the walk ends on empty leaf 0.
      add_row(wsst_pkg::ACT_SET,    10'h3FF, 32'd1,        16'd0,    1, 10'h3FF, 32'd0,
              42'd1);
      add_row(wsst_pkg::ACT_SELECT, 10'h3FF, 32'd0,        16'hFFFF, 1, 10'd0,   32'd0,
              42'd1);
      add_row(wsst_pkg::ACT_CLEAR,  10'd0,   32'd0,        16'd0,    1, 10'd0,   32'd0,
              42'd0);

      send_idle_pct = 29;
      recv_idle_pct = 52;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_op(directed_rows[i].op, directed_rows[i].fixed, directed_rows[i].want);
      for (n = 0; n < 200; n++)
         issue_op(random_op(), 0, none);

      send_idle_pct = 52;
      recv_idle_pct = 29;
      for (n = 0; n < 200; n++)
         issue_op(random_op(), 0, none);

      // No idling: load every leaf near full weight so the total reaches its top bits.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (leaf = 0; leaf < LEAF_COUNT; leaf++) begin
         op.action   = wsst_pkg::ACT_SET;
         op.leaf     = wsst_pkg::INDEX_W'(leaf);
         op.weight   = 32'hFFFFFFFF - $urandom_range(0, 65535);
         op.fraction = wsst_pkg::RAND_W'($urandom_range(0, 65535));
         issue_op(op, 0, none);
         if (leaf % 8 == 7) begin
            op.action = wsst_pkg::ACT_SELECT;
            op.fraction = wsst_pkg::RAND_W'($urandom_range(0, 65535));
            issue_op(op, 0, none);
            op.action = wsst_pkg::ACT_GET;
            op.leaf   = wsst_pkg::INDEX_W'($urandom_range(0, LEAF_COUNT - 1));
            issue_op(op, 0, none);
         end
      end
      for (n = 0; n < 50; n++)
         issue_op(random_op(), 0, none);
      req_valid <= 1'b0;

      // Drain, then give a stray extra item time to show up.
      while (tree_results_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("PASS weighted_sample_sum_tree_unit");
      else
         $display("FAIL weighted_sample_sum_tree_unit");
      $finish;
   end

   // Watchdog: several times the slowest correct run, clears and the reset sweep included.
   initial begin
      #5_000_000;
      $display("FAIL weighted_sample_sum_tree_unit");
      $finish;
   end

endmodule
